[rtl/pmhs_pkg.sv]
// Package: codes, result type and command script ROM for the PS/2 mouse host sequencer.
`timescale 1ns / 1ps
package pmhs_pkg;

  typedef enum logic [2:0] {
    OP_INIT    = 3'd0,
    OP_OPEN    = 3'd1,
    OP_CLOSE   = 3'd2,
    OP_RX      = 3'd3,
    OP_TX_DONE = 3'd4,
    OP_TIMEOUT = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_DONE = 2'd1,
    KIND_MOVE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PROTO_CLASSIC = 2'd0,
    PROTO_WHEEL   = 2'd1,
    PROTO_FIVE    = 2'd2
  } proto_t;

  typedef enum logic [2:0] {
    SC_RESET = 3'd0,
    SC_FIVE  = 3'd1,
    SC_WHEEL = 3'd2,
    SC_SETUP = 3'd3,
    SC_OPEN  = 3'd4,
    SC_CLOSE = 3'd5,
    SC_NONE  = 3'd7
  } script_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tx_byte;
    logic        ok;
    proto_t      protocol;
    logic [4:0]  buttons;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
    logic [7:0]  wheel_byte;
  } res_t;

  // Mouse command and reply bytes
  localparam logic [7:0] CMD_RESET    = 8'hFF;
  localparam logic [7:0] CMD_SET_RATE = 8'hF3;
  localparam logic [7:0] CMD_GET_ID   = 8'hF2;
  localparam logic [7:0] CMD_SCALE11  = 8'hE6;
  localparam logic [7:0] CMD_ENABLE   = 8'hF4;
  localparam logic [7:0] CMD_DISABLE  = 8'hF5;
  localparam logic [7:0] RSP_ACK      = 8'hFA;
  localparam logic [7:0] RSP_BAT_OK   = 8'hAA;
  localparam logic [7:0] ID_MOUSE     = 8'h00;
  localparam logic [7:0] ID_WHEEL     = 8'h03;
  localparam logic [7:0] ID_FIVE      = 8'h04;
  localparam logic [7:0] RATE_200     = 8'hC8;
  localparam logic [7:0] RATE_100     = 8'h64;
  localparam logic [7:0] RATE_80      = 8'h50;
  localparam logic [7:0] RATE_10      = 8'h0A;

  // bit 8 set: send the byte; clear: expect the byte
  localparam logic [8:0] TX_F = 9'h100;

  function automatic logic [8:0] snd(input logic [7:0] b);
    snd = TX_F | {1'b0, b};
  endfunction

  function automatic logic [8:0] exp_b(input logic [7:0] b);
    exp_b = {1'b0, b};
  endfunction

  function automatic logic [4:0] rom_len(input script_t s);
    case (s)
      SC_RESET: rom_len = 5'd6;
      SC_FIVE:  rom_len = 5'd15;
      SC_WHEEL: rom_len = 5'd15;
      SC_SETUP: rom_len = 5'd6;
      SC_OPEN:  rom_len = 5'd2;
      SC_CLOSE: rom_len = 5'd2;
      default:  rom_len = 5'd0;
    endcase
  endfunction

  // Five and wheel probes share the knock except the middle rate and final ID.
  function automatic logic [8:0] probe_entry(input logic [3:0] i, input logic wheel);
    case (i)
      4'd0, 4'd4, 4'd8: probe_entry = snd(CMD_SET_RATE);
      4'd2:             probe_entry = snd(RATE_200);
      4'd6:             probe_entry = wheel ? snd(RATE_100) : snd(RATE_200);
      4'd10:            probe_entry = snd(RATE_80);
      4'd12:            probe_entry = snd(CMD_GET_ID);
      4'd14:            probe_entry = wheel ? exp_b(ID_WHEEL) : exp_b(ID_FIVE);
      4'd15:            probe_entry = 9'd0;
      default:          probe_entry = exp_b(RSP_ACK);
    endcase
  endfunction

  function automatic logic [8:0] rom_entry(input script_t s, input logic [3:0] i);
    rom_entry = 9'd0;
    case (s)
      SC_RESET: begin
        case (i)
          4'd0:    rom_entry = snd(CMD_RESET);
          4'd1:    rom_entry = exp_b(RSP_ACK);
          4'd2:    rom_entry = exp_b(RSP_BAT_OK);
          4'd3:    rom_entry = exp_b(ID_MOUSE);
          4'd4:    rom_entry = snd(CMD_SET_RATE);
          4'd5:    rom_entry = exp_b(RSP_ACK);
          default: rom_entry = 9'd0;
        endcase
      end
      SC_FIVE:  rom_entry = probe_entry(i, 1'b0);
      SC_WHEEL: rom_entry = probe_entry(i, 1'b1);
      SC_SETUP: begin
        case (i)
          4'd0:    rom_entry = snd(CMD_SCALE11);
          4'd2:    rom_entry = snd(CMD_SET_RATE);
          4'd4:    rom_entry = snd(RATE_10);
          4'd1, 4'd3, 4'd5: rom_entry = exp_b(RSP_ACK);
          default: rom_entry = 9'd0;
        endcase
      end
      SC_OPEN: begin
        case (i)
          4'd0:    rom_entry = snd(CMD_ENABLE);
          4'd1:    rom_entry = exp_b(RSP_ACK);
          default: rom_entry = 9'd0;
        endcase
      end
      SC_CLOSE: begin
        case (i)
          4'd0:    rom_entry = snd(CMD_DISABLE);
          4'd1:    rom_entry = exp_b(RSP_ACK);
          default: rom_entry = 9'd0;
        endcase
      end
      default: rom_entry = 9'd0;
    endcase
  endfunction

endpackage

[rtl/pmhs_if.sv]
// Interfaces: input event channel and result channel, valid/ready handshake.
`timescale 1ns / 1ps
interface pmhs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] rx_byte;
  logic       send_failed;

  modport source (output valid, op, rx_byte, send_failed, input ready);
  modport sink   (input valid, op, rx_byte, send_failed, output ready);
endinterface

interface pmhs_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [7:0]        tx_byte;
  logic              ok;
  logic [1:0]        protocol;
  logic [4:0]        buttons;
  logic signed [7:0] dx;
  logic signed [7:0] dy;
  logic [7:0]        wheel_byte;

  modport source (output valid, kind, tx_byte, ok, protocol, buttons, dx, dy, wheel_byte,
                  input ready);
  modport sink   (input valid, kind, tx_byte, ok, protocol, buttons, dx, dy, wheel_byte,
                  output ready);
endinterface

[rtl/pmhs_step.sv]
// Sequencer state and combinational step logic: script runner and packet assembler.
`timescale 1ns / 1ps
module pmhs_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [2:0]       op,
  input  logic [7:0]       rx_byte,
  input  logic             send_failed,
  output logic             res_valid,
  output pmhs_pkg::res_t   res
);
  import pmhs_pkg::*;

  script_t    script_r, script_nxt;
  logic [3:0] step_r, step_nxt;
  logic [7:0] pkt_r   [4];
  logic [7:0] pkt_nxt [4];
  logic [1:0] cnt_r, cnt_nxt;
  logic       four_r, four_nxt;
  logic       five_r, five_nxt;

  logic       running;
  logic [8:0] ent, ent_n, ent_s;
  logic [4:0] adv_n;
  logic [2:0] cnt_inc;
  logic       adv, end_scr, good, start, fin, fin_ok;
  logic       emit_tx, emit_move;
  logic [7:0] tx_val;
  script_t    start_s;

  assign running = (script_r != SC_NONE);

  always_comb begin
    script_nxt = script_r;
    step_nxt   = step_r;
    pkt_nxt    = pkt_r;
    cnt_nxt    = cnt_r;
    four_nxt   = four_r;
    five_nxt   = five_r;
    adv        = 1'b0;
    end_scr    = 1'b0;
    good       = 1'b0;
    start      = 1'b0;
    start_s    = SC_NONE;
    fin        = 1'b0;
    fin_ok     = 1'b0;
    emit_tx    = 1'b0;
    emit_move  = 1'b0;
    tx_val     = 8'd0;
    adv_n      = {1'b0, step_r} + 5'd1;
    ent        = rom_entry(script_r, step_r);
    ent_n      = rom_entry(script_r, adv_n[3:0]);
    cnt_inc    = {1'b0, cnt_r} + 3'd1;
    res        = '0;

    if (running) begin
      if ({1'b0, step_r} >= rom_len(script_r)) begin
        end_scr = 1'b1;
      end else begin
        case (op)
          OP_RX: begin
            if (!ent[8]) begin
              if (rx_byte == ent[7:0]) adv = 1'b1;
              else end_scr = 1'b1;
            end
          end
          OP_TX_DONE: begin
            if (ent[8]) begin
              if (send_failed) end_scr = 1'b1;
              else adv = 1'b1;
            end
          end
          OP_TIMEOUT: end_scr = 1'b1;
          default: ;
        endcase
      end

      if (adv) begin
        if (adv_n >= rom_len(script_r)) begin
          end_scr = 1'b1;
          good    = 1'b1;
        end else begin
          step_nxt = adv_n[3:0];
          if (ent_n[8]) begin
            emit_tx = 1'b1;
            tx_val  = ent_n[7:0];
          end
        end
      end

      if (end_scr) begin
        case (script_r)
          SC_RESET: begin
            if (good) begin
              start   = 1'b1;
              start_s = SC_FIVE;
            end else begin
              fin = 1'b1;
            end
          end
          SC_FIVE: begin
            five_nxt = good;
            start    = 1'b1;
            if (good) begin
              four_nxt = 1'b1;
              start_s  = SC_SETUP;
            end else begin
              start_s  = SC_WHEEL;
            end
          end
          SC_WHEEL: begin
            four_nxt = good;
            start    = 1'b1;
            start_s  = SC_SETUP;
          end
          SC_SETUP: begin
            fin    = 1'b1;
            fin_ok = 1'b1;
          end
          SC_OPEN: begin
            cnt_nxt = 2'd0;
            fin     = 1'b1;
            fin_ok  = good;
          end
          default: begin
            fin    = 1'b1;
            fin_ok = good;
          end
        endcase
      end
    end else begin
      case (op)
        OP_INIT: begin
          start   = 1'b1;
          start_s = SC_RESET;
        end
        OP_OPEN: begin
          start   = 1'b1;
          start_s = SC_OPEN;
        end
        OP_CLOSE: begin
          start   = 1'b1;
          start_s = SC_CLOSE;
        end
        OP_RX: begin
          pkt_nxt[cnt_r] = rx_byte;
          if (cnt_inc < (four_r ? 3'd4 : 3'd3)) begin
            cnt_nxt = cnt_inc[1:0];
          end else begin
            cnt_nxt   = 2'd0;
            emit_move = 1'b1;
          end
        end
        default: ;
      endcase
    end

    ent_s = rom_entry(start_s, 4'd0);
    if (start) begin
      script_nxt = start_s;
      step_nxt   = 4'd0;
      emit_tx    = 1'b1;
      tx_val     = ent_s[7:0];
    end
    if (fin) begin
      script_nxt = SC_NONE;
      step_nxt   = 4'd0;
    end

    if (five_nxt)      res.protocol = PROTO_FIVE;
    else if (four_nxt) res.protocol = PROTO_WHEEL;
    else               res.protocol = PROTO_CLASSIC;

    if (emit_tx) begin
      res.kind    = KIND_TX;
      res.tx_byte = tx_val;
    end else if (fin) begin
      res.kind = KIND_DONE;
      res.ok   = fin_ok;
    end else if (emit_move) begin
      res.kind       = KIND_MOVE;
      res.buttons    = {five_r ? pkt_nxt[3][4:3] : 2'b00, pkt_nxt[0][2:0]};
      res.dx         = {pkt_nxt[0][4], pkt_nxt[1][7:1]};
      res.dy         = {pkt_nxt[0][5], pkt_nxt[2][7:1]};
      res.wheel_byte = four_r ? {pkt_nxt[3][2:0], 5'd0} : 8'd0;
    end
  end

  assign res_valid = emit_tx | fin | emit_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      script_r <= SC_NONE;
      step_r   <= 4'd0;
      cnt_r    <= 2'd0;
      four_r   <= 1'b1;
      five_r   <= 1'b0;
      for (int i = 0; i < 4; i++) pkt_r[i] <= 8'd0;
    end else if (fire) begin
      script_r <= script_nxt;
      step_r   <= step_nxt;
      cnt_r    <= cnt_nxt;
      four_r   <= four_nxt;
      five_r   <= five_nxt;
      pkt_r    <= pkt_nxt;
    end
  end

  // Step pointer stays inside the running script, and parks at zero when idle.
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    running |-> ({1'b0, step_r} < rom_len(script_r)))
    else $error("script step past end of script");

  a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !running |-> (step_r == 4'd0))
    else $error("step not cleared while idle");

  a_tx_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_valid && res.kind == KIND_TX) |=> running)
    else $error("transmit issued with no script running");

  a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_valid && res.kind == KIND_DONE) |=> !running)
    else $error("command finished but script still running");

  a_five_implies_four: assert property (@(posedge clk) disable iff (!rst_n)
    five_r |-> four_r)
    else $error("five-button mode without four-byte packets");

endmodule

[rtl/ps2_mouse_host_sequencer_unit.sv]
// Top level: input register, sequencer step, result register.
// A transaction is held in the input register, then its result (if any) in the result register.
// Throughput: one transaction per cycle unless output is full; step logic is combinational.
// Result register frees in the cycle out.ready is high, so input stalls only on a full output.
// Reset (rst_n low, synchronous): no script running, packet count zero,
// four-byte packets on, five-button mode off, both pipeline stages empty.
`timescale 1ns / 1ps
module ps2_mouse_host_sequencer_unit (
  input  logic       clk,
  input  logic       rst_n,
  pmhs_in_if.sink    in_chan,
  pmhs_out_if.source out_chan
);
  import pmhs_pkg::*;

  logic       s1_v_r;
  logic [2:0] s1_op_r;
  logic [7:0] s1_rx_r;
  logic       s1_fail_r;
  logic       out_v_r, out_v_nxt;
  res_t       out_res_r;

  logic       s2_free, s1_adv;
  logic       res_valid;
  res_t       res;

  assign s2_free       = !out_v_r || out_chan.ready;
  assign s1_adv        = s1_v_r && s2_free;
  assign in_chan.ready = !s1_v_r || s2_free;

  pmhs_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (s1_adv),
    .op          (s1_op_r),
    .rx_byte     (s1_rx_r),
    .send_failed (s1_fail_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_comb begin
    if (s1_adv)              out_v_nxt = res_valid;
    else if (out_chan.ready) out_v_nxt = 1'b0;
    else                     out_v_nxt = out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_chan.ready) s1_v_r <= in_chan.valid;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_op_r   <= in_chan.op;
      s1_rx_r   <= in_chan.rx_byte;
      s1_fail_r <= in_chan.send_failed;
    end
    if (s1_adv && res_valid) out_res_r <= res;
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.kind       = out_res_r.kind;
  assign out_chan.tx_byte    = out_res_r.tx_byte;
  assign out_chan.ok         = out_res_r.ok;
  assign out_chan.protocol   = out_res_r.protocol;
  assign out_chan.buttons    = out_res_r.buttons;
  assign out_chan.dx         = out_res_r.dx;
  assign out_chan.dy         = out_res_r.dy;
  assign out_chan.wheel_byte = out_res_r.wheel_byte;

endmodule

[tb/ps2_mouse_host_sequencer_unit_tb.sv]
// Self-checking testbench for the PS/2 mouse host sequencer: scripted mouse traffic plus packets.
`timescale 1ns / 1ps
module ps2_mouse_host_sequencer_unit_tb;
  import pmhs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_LEN    = 300;
  localparam int PHASE_ITEMS = 430;

  typedef enum int {
    SEQ_RESET, SEQ_FIVE, SEQ_WHEEL, SEQ_SETUP, SEQ_OPEN, SEQ_CLOSE, SEQ_IDLE
  } seq_t;

  typedef struct {
    logic [2:0] op;
    logic [7:0] rx;
    logic       fail;
  } mouse_ev_t;

  // Predicts the sequencer and holds the results still owed by the block.
  class mouse_seq_scoreboard;
    res_t       owed_q[$];
    int         fails;
    int         reported;
    seq_t       script;
    logic [3:0] step;
    logic [7:0] pkt[4];
    logic [1:0] pkt_n;
    bit         four_byte;
    bit         five_btn;
    logic [8:0] rom[6][16];
    int         rom_n[6];

    function new();
      logic [7:0] knock[7];
      logic [7:0] setup[3];
      fails = 0;
      reported = 0;
      foreach (rom[s, i]) rom[s][i] = '0;
      // bit 8 marks a byte to send, otherwise a byte to wait for
      rom[SEQ_RESET][0] = {1'b1, CMD_RESET};
      rom[SEQ_RESET][1] = {1'b0, RSP_ACK};
      rom[SEQ_RESET][2] = {1'b0, RSP_BAT_OK};
      rom[SEQ_RESET][3] = {1'b0, ID_MOUSE};
      rom[SEQ_RESET][4] = {1'b1, CMD_SET_RATE};
      rom[SEQ_RESET][5] = {1'b0, RSP_ACK};
      knock = '{CMD_SET_RATE, RATE_200, CMD_SET_RATE, RATE_200, CMD_SET_RATE, RATE_80,
                CMD_GET_ID};
      setup = '{CMD_SCALE11, CMD_SET_RATE, RATE_10};
      for (int i = 0; i < 7; i++) begin
        rom[SEQ_FIVE][2*i]    = {1'b1, knock[i]};
        rom[SEQ_FIVE][2*i+1]  = {1'b0, RSP_ACK};
        rom[SEQ_WHEEL][2*i]   = {1'b1, (i == 3) ? RATE_100 : knock[i]};
        rom[SEQ_WHEEL][2*i+1] = {1'b0, RSP_ACK};
      end
      rom[SEQ_FIVE][14]  = {1'b0, ID_FIVE};
      rom[SEQ_WHEEL][14] = {1'b0, ID_WHEEL};
      for (int i = 0; i < 3; i++) begin
        rom[SEQ_SETUP][2*i]   = {1'b1, setup[i]};
        rom[SEQ_SETUP][2*i+1] = {1'b0, RSP_ACK};
      end
      rom[SEQ_OPEN][0]  = {1'b1, CMD_ENABLE};
      rom[SEQ_OPEN][1]  = {1'b0, RSP_ACK};
      rom[SEQ_CLOSE][0] = {1'b1, CMD_DISABLE};
      rom[SEQ_CLOSE][1] = {1'b0, RSP_ACK};
      rom_n = '{6, 15, 15, 6, 2, 2};
      script = SEQ_IDLE;
      step = '0;
      foreach (pkt[i]) pkt[i] = '0;
      pkt_n = '0;
      four_byte = 1'b1;
      five_btn = 1'b0;
    endfunction

    function proto_t proto();
      if (five_btn) return PROTO_FIVE;
      return four_byte ? PROTO_WHEEL : PROTO_CLASSIC;
    endfunction

    function void push_tx(logic [7:0] b);
      res_t r;
      r = '0;
      r.kind = KIND_TX;
      r.tx_byte = b;
      r.protocol = proto();
      owed_q.push_back(r);
    endfunction

    function void launch(seq_t s);
      script = s;
      step = '0;
      push_tx(rom[s][0][7:0]);
    endfunction

    function void done(bit good);
      res_t r;
      script = SEQ_IDLE;
      step = '0;
      r = '0;
      r.kind = KIND_DONE;
      r.ok = good;
      r.protocol = proto();
      owed_q.push_back(r);
    endfunction

    function void end_script(bit good);
      case (script)
        SEQ_RESET: begin
          if (good) launch(SEQ_FIVE);
          else done(1'b0);
        end
        SEQ_FIVE: begin
          five_btn = good;
          if (good) begin
            four_byte = 1'b1;
            launch(SEQ_SETUP);
          end else begin
            launch(SEQ_WHEEL);
          end
        end
        SEQ_WHEEL: begin
          four_byte = good;
          launch(SEQ_SETUP);
        end
        SEQ_SETUP: done(1'b1);  // setup outcome does not matter
        SEQ_OPEN: begin
          pkt_n = '0;
          done(good);
        end
        default: done(good);
      endcase
    endfunction

    function void step_on();
      int n;
      n = step + 1;
      if (n >= rom_n[script]) begin
        end_script(1'b1);
      end else begin
        step = n[3:0];
        if (rom[script][n][8]) push_tx(rom[script][n][7:0]);
      end
    endfunction

    function void take_byte(logic [7:0] b);
      res_t r;
      int   n;
      n = pkt_n;
      pkt[n] = b;
      n++;
      if (n < (four_byte ? 4 : 3)) begin
        pkt_n = n[1:0];
      end else begin
        pkt_n = '0;
        r = '0;
        r.kind = KIND_MOVE;
        r.protocol = proto();
        r.buttons = {five_btn ? pkt[3][4:3] : 2'b00, pkt[0][2:0]};
        r.dx = {pkt[0][4], pkt[1][7:1]};
        r.dy = {pkt[0][5], pkt[2][7:1]};
        r.wheel_byte = four_byte ? {pkt[3][2:0], 5'b0} : 8'h00;
        owed_q.push_back(r);
      end
    endfunction

    // Returns 0 for a transaction that the block ignores.
    function bit note_event(mouse_ev_t ev);
      logic [8:0] cur;
      if (script != SEQ_IDLE) begin
        cur = rom[script][step];
        if (ev.op == OP_RX) begin
          if (cur[8]) return 1'b0;
          if (ev.rx == cur[7:0]) step_on();
          else end_script(1'b0);
          return 1'b1;
        end
        if (ev.op == OP_TX_DONE) begin
          if (!cur[8]) return 1'b0;
          if (ev.fail) end_script(1'b0);
          else step_on();
          return 1'b1;
        end
        if (ev.op == OP_TIMEOUT) begin
          end_script(1'b0);
          return 1'b1;
        end
        return 1'b0;
      end
      case (ev.op)
        OP_INIT:  launch(SEQ_RESET);
        OP_OPEN:  launch(SEQ_OPEN);
        OP_CLOSE: launch(SEQ_CLOSE);
        OP_RX:    take_byte(ev.rx);
        default:  return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function string show(res_t r);
      return $sformatf("kind=%0d tx=%02h ok=%0b proto=%0d btn=%02h dx=%0d dy=%0d wheel=%02h",
                       r.kind, r.tx_byte, r.ok, r.protocol, r.buttons, $signed(r.dx),
                       $signed(r.dy), r.wheel_byte);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (owed_q.size() == 0) begin
        fails++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result: %s", show(got));
        end
        return;
      end
      want = owed_q.pop_front();
      if (got.kind !== want.kind || got.tx_byte !== want.tx_byte || got.ok !== want.ok ||
          got.protocol !== want.protocol || got.buttons !== want.buttons ||
          got.dx !== want.dx || got.dy !== want.dy || got.wheel_byte !== want.wheel_byte) begin
        fails++;
        if (reported < 10) begin
          reported++;
          $display("mismatch at %0t: expected %s", $realtime, show(want));
          $display("                   actual %s", show(got));
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  pmhs_in_if  in_if();
  pmhs_out_if out_if();

  mouse_seq_scoreboard sb = new();
  int   in_idle;
  int   out_idle;
  int   hold_kicks = 0;
  int   acted_n = 0;
  int   cycle_n = 0;
  res_t got;

  ps2_mouse_host_sequencer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic mouse_ev_t mk(logic [2:0] op, logic [7:0] rx, logic fail);
    mouse_ev_t ev;
    ev.op = op;
    ev.rx = rx;
    ev.fail = fail;
    return ev;
  endfunction

  // Mostly what a well-behaved mouse would answer next, with some faults and noise.
  function automatic mouse_ev_t pick_event();
    mouse_ev_t  ev;
    logic [8:0] cur;
    int         r;
    ev = mk(OP_RX, 8'($urandom_range(255)), 1'($urandom_range(1)));
    r = $urandom_range(99);
    if (sb.script != SEQ_IDLE) begin
      cur = sb.rom[sb.script][sb.step];
      if (r < 3) begin
        ev.op = 3'($urandom_range(7));
      end else if (r < 4) begin
        ev.op = OP_TIMEOUT;
      end else if (cur[8]) begin
        ev.op = OP_TX_DONE;
        ev.fail = ($urandom_range(99) < 2);
      end else if (sb.step == 4'd14) begin
        // device ID answer decides which probe passes
        case ($urandom_range(3))
          0: ev.rx = ID_FIVE;
          1: ev.rx = ID_WHEEL;
          2: ev.rx = ID_MOUSE;
          default: ;
        endcase
      end else if ($urandom_range(99) >= 2) begin
        ev.rx = cur[7:0];
      end
    end else begin
      if (r < 3) ev.op = OP_INIT;
      else if (r < 5) ev.op = OP_OPEN;
      else if (r < 7) ev.op = OP_CLOSE;
      else if (r < 10) ev.op = 3'($urandom_range(4, 7));
    end
    return ev;
  endfunction

  task automatic send_event(input mouse_ev_t ev);
    @(negedge clk);
    while ($urandom_range(99) < in_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.op          <= ev.op;
    in_if.rx_byte     <= ev.rx;
    in_if.send_failed <= ev.fail;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    if (sb.note_event(ev)) acted_n++;
  endtask

  // receiver: random back-pressure plus one long hold-off on request
  initial begin
    int hold_left;
    int kicks_seen;
    hold_left = 0;
    kicks_seen = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (kicks_seen != hold_kicks) begin
        kicks_seen = hold_kicks;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= out_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      got.kind       = kind_t'(out_if.kind);
      got.tx_byte    = out_if.tx_byte;
      got.ok         = out_if.ok;
      got.protocol   = proto_t'(out_if.protocol);
      got.buttons    = out_if.buttons;
      got.dx         = out_if.dx;
      got.dy         = out_if.dy;
      got.wheel_byte = out_if.wheel_byte;
      sb.check_result(got);
    end
  end

  initial begin
    while (cycle_n < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_n++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = OP_RX;
    in_if.rx_byte = 8'h00;
    in_if.send_failed = 1'b0;
    in_idle = 12;
    out_idle = 58;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // packets at the extremes, power-up mode is four-byte
    send_event(mk(OP_RX, 8'h3F, 1'b0));
    send_event(mk(OP_RX, 8'h00, 1'b0));
    send_event(mk(OP_RX, 8'hFF, 1'b0));
    send_event(mk(OP_RX, 8'hFF, 1'b0));
    send_event(mk(OP_RX, 8'h08, 1'b0));
    send_event(mk(OP_RX, 8'hFF, 1'b0));
    send_event(mk(OP_RX, 8'h00, 1'b0));
    send_event(mk(OP_RX, 8'h00, 1'b0));
    // unused codes, timeout and send done with nothing running
    send_event(mk(3'd6, 8'h00, 1'b0));
    send_event(mk(3'd7, 8'hFF, 1'b1));
    send_event(mk(OP_TIMEOUT, 8'h00, 1'b0));
    send_event(mk(OP_TX_DONE, 8'h00, 1'b0));
    // open with stray events: command, early byte, extra send done
    send_event(mk(OP_OPEN, 8'h00, 1'b0));
    send_event(mk(OP_CLOSE, 8'h00, 1'b0));
    send_event(mk(OP_RX, RSP_ACK, 1'b0));
    send_event(mk(OP_TX_DONE, 8'h00, 1'b0));
    send_event(mk(OP_TX_DONE, 8'h00, 1'b0));
    send_event(mk(OP_RX, RSP_ACK, 1'b0));
    // close with a failed send
    send_event(mk(OP_CLOSE, 8'h00, 1'b0));
    send_event(mk(OP_TX_DONE, 8'h00, 1'b1));
    // init whose reset times out
    send_event(mk(OP_INIT, 8'h00, 1'b0));
    send_event(mk(OP_TIMEOUT, 8'h00, 1'b0));
    // a failed open still drops the partial packet
    send_event(mk(OP_RX, 8'h01, 1'b0));
    send_event(mk(OP_OPEN, 8'h00, 1'b0));
    send_event(mk(OP_TIMEOUT, 8'h00, 1'b0));

    for (int ph = 0; ph < 3; ph++) begin
      int goal;
      goal = acted_n + PHASE_ITEMS;
      case (ph)
        0: hold_kicks++;
        1: begin
          in_idle = 58;
          out_idle = 12;
        end
        default: begin
          in_idle = 0;
          out_idle = 0;
        end
      endcase
      while (acted_n < goal) send_event(pick_event());
    end

    @(negedge clk) in_if.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.fails == 0 && sb.owed_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/pmhs_pkg.sv
rtl/pmhs_if.sv
rtl/pmhs_step.sv
rtl/ps2_mouse_host_sequencer_unit.sv
tb/ps2_mouse_host_sequencer_unit_tb.sv
